// ===== rtl/spfa_pkg.sv =====
// shared types, constants and saturation helpers for the sph pair force accumulator
package spfa_pkg;

  localparam int FRAC_BITS_DEF = 16;

  localparam int IN_TDATA_W  = 352;
  localparam int OUT_TDATA_W = 96;
  localparam int CFG_IDX_W   = 3;

  localparam int POS_X_LSB    = 0;
  localparam int POS_Y_LSB    = 32;
  localparam int VEL_X_LSB    = 64;
  localparam int VEL_Y_LSB    = 96;
  localparam int DENSITY_LSB  = 128;
  localparam int PRESSURE_LSB = 159;
  localparam int SMOOTH_LSB   = 191;
  localparam int SOUND_LSB    = 222;
  localparam int MASS_LSB     = 253;
  localparam int GRAD_X_LSB   = 284;
  localparam int GRAD_Y_LSB   = 316;

  localparam logic [1:0] ACT_LOAD     = 2'd0;
  localparam logic [1:0] ACT_NEIGHBOR = 2'd1;
  localparam logic [1:0] ACT_BOUNDARY = 2'd2;
  localparam logic [1:0] ACT_EMIT     = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_GRAVITY    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BND_RADIUS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BND_STRENG = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_VISC_ALPHA = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_VISC_BETA  = 3'd4;

  localparam logic signed [31:0] GRAVITY_RST = -32'sd642908;
  localparam logic [30:0] BND_RADIUS_RST = 31'd655;
  localparam logic [30:0] BND_STRENG_RST = 31'd655;
  localparam logic [30:0] VISC_ALPHA_RST = 31'd65536;
  localparam logic [30:0] VISC_BETA_RST  = 31'd65536;

  typedef enum logic [5:0] {
    OP_NONE, OP_LOAD, OP_EMIT, OP_DIFF,
    OP_VDW1, OP_VDW2, OP_VR1, OP_VR2, OP_R21, OP_R22,
    OP_WD0, OP_WD1, OP_WPIJ,
    OP_T, OP_AX, OP_AY, OP_AE,
    OP_V1, OP_WPHI, OP_V3, OP_V4, OP_V5, OP_V6, OP_WCOEF,
    OP_WR, OP_WQ, OP_Q2, OP_Q4, OP_Q8, OP_Q12, OP_B7, OP_WFAC, OP_BX, OP_BY
  } op_t;

  typedef enum logic [2:0] {
    DS_PI_C, DS_PI_C2, DS_PI_N, DS_PI_N2, DS_P0R2, DS_PIIJ, DS_Q
  } dsel_t;

  typedef struct packed {
    op_t   op;
    logic  div_go;
    dsel_t dsel;
    logic  sqrt_go;
  } cmd_t;

  typedef struct packed {
    logic [1:0] action;
    logic       vr_neg;
    logic       r_lt_r0;
    logic       div_busy;
    logic       sqrt_busy;
    logic       emit_ok;
  } stat_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    if (x > 64'sd2147483647) return 32'sh7fffffff;
    else if (x < -64'sd2147483648) return 32'sh80000000;
    else return x[31:0];
  endfunction

  function automatic logic signed [47:0] sat48(input logic signed [63:0] x);
    if (x > 64'sd140737488355327) return 48'sh7fffffffffff;
    else if (x < -64'sd140737488355328) return 48'sh800000000000;
    else return x[47:0];
  endfunction

endpackage

// ===== rtl/spfa_div.sv =====
// shared restoring divider, quotient of (a * 2^frac) / b truncated toward zero, saturated
module spfa_div #(
  parameter int FRAC_BITS = spfa_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               go,
  input  logic signed [31:0] a,
  input  logic [31:0]        b,
  output logic               busy,
  output logic signed [31:0] q
);

  localparam int NW = 32 + FRAC_BITS;
  localparam int CW = $clog2(NW + 1);

  logic [CW-1:0] cnt;
  logic [NW-1:0] quo;
  logic [31:0]   rem;
  logic [31:0]   den;
  logic          neg;
  logic [31:0]   mag;
  logic [32:0]   trial;
  logic          fits;

  assign mag   = a[31] ? (~a + 32'd1) : a;
  assign trial = {rem, quo[NW-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (go) begin
      busy <= 1'b1;
      cnt  <= CW'(NW);
    end else if (busy) begin
      cnt  <= cnt - CW'(1);
      busy <= (cnt != CW'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      quo <= {mag, {FRAC_BITS{1'b0}}};
      rem <= '0;
      den <= b;
      neg <= a[31];
    end else if (busy) begin
      if (trial >= {1'b0, den}) begin
        rem <= 32'(trial - {1'b0, den});
        quo <= {quo[NW-2:0], 1'b1};
      end else begin
        rem <= trial[31:0];
        quo <= {quo[NW-2:0], 1'b0};
      end
    end
  end

  assign fits = ~|quo[NW-1:32];

  always_comb begin
    if (!neg) begin
      q = (fits && !quo[31]) ? $signed(quo[31:0]) : 32'sh7fffffff;
    end else begin
      q = (fits && !(quo[31] && |quo[30:0])) ? $signed(~quo[31:0] + 32'd1)
                                               : 32'sh80000000;
    end
  end

endmodule

// ===== rtl/spfa_sqrt.sv =====
// bit-serial floor square root of r2 * 2^frac, two radicand bits per cycle
module spfa_sqrt #(
  parameter int FRAC_BITS = spfa_pkg::FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        go,
  input  logic [30:0] r2,
  output logic        busy,
  output logic [31:0] root
);

  localparam int SW = ((31 + FRAC_BITS + 1) / 2) * 2;

  logic [SW-1:0] v;
  logic [SW-1:0] res;
  logic [SW-1:0] bt;
  logic [SW-1:0] sum;

  assign sum  = res + bt;
  assign root = res[31:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (go) begin
      busy <= 1'b1;
    end else if (busy) begin
      busy <= ~bt[0];
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      v   <= SW'({r2, {FRAC_BITS{1'b0}}});
      res <= '0;
      bt  <= {2'b01, {(SW-2){1'b0}}};
    end else if (busy) begin
      if (v >= sum) begin
        v   <= v - sum;
        res <= (res >> 1) + bt;
      end else begin
        res <= res >> 1;
      end
      bt <= bt >> 2;
    end
  end

endmodule

// ===== rtl/spfa_datapath.sv =====
// datapath: center and config registers, shared multiplier, divider, root unit, sums
module spfa_datapath #(
  parameter int FRAC_BITS = spfa_pkg::FRAC_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_wen,
  input  logic [spfa_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [31:0]                          cfg_data,
  input  logic                                 in_take,
  input  logic [1:0]                           in_action,
  input  logic [spfa_pkg::IN_TDATA_W-1:0]      in_data,
  input  logic                                 out_ready,
  output logic                                 out_valid,
  output logic [spfa_pkg::OUT_TDATA_W-1:0]     out_data,
  input  spfa_pkg::cmd_t                       cmd,
  output spfa_pkg::stat_t                      stat
);

  logic signed [31:0] gravity;
  logic [30:0] r0, dstr, alpha, beta;

  logic signed [31:0] c_px, c_py, c_vx, c_vy, c_p;
  logic [30:0] c_rho, c_h, c_c;
  logic signed [31:0] n_px, n_py, n_vx, n_vy, n_p, n_gx, n_gy;
  logic [30:0] n_rho, n_h, n_c, n_m;
  logic [1:0] n_act;

  logic signed [47:0] sum_x, sum_y, sum_e;

  logic signed [31:0] xij, yij, vxij, vyij, vdw, vr, r2;
  logic [30:0] rhoi, rhoj, hij, cij, rhoij;
  logic signed [31:0] p0, p1, d0, d1, coef, t, phi, num;
  logic signed [31:0] q, q2, q4, q8, q12, fac;
  logic [31:0] r;

  logic signed [31:0] ma, mb, mres;
  logic signed [63:0] mprod, mshift;

  logic signed [31:0] da;
  logic [31:0] db;
  logic div_busy, sqrt_busy;
  logic signed [31:0] dq;
  logic [31:0] sroot;
  logic emit_ok;

  logic [30:0] rhoi_c, rhoj_c;
  logic [31:0] hsum, csum, rsum;

  assign rhoi_c = (c_rho == '0) ? 31'd1 : c_rho;
  assign rhoj_c = (n_rho == '0) ? 31'd1 : n_rho;
  assign hsum   = {1'b0, c_h} + {1'b0, n_h};
  assign csum   = {1'b0, c_c} + {1'b0, n_c};
  assign rsum   = {1'b0, rhoi_c} + {1'b0, rhoj_c};

  // shared multiplier, floor shift and saturate
  always_comb begin
    case (cmd.op)
      spfa_pkg::OP_VDW1: begin ma = vxij; mb = n_gx; end
      spfa_pkg::OP_VDW2: begin ma = vyij; mb = n_gy; end
      spfa_pkg::OP_VR1:  begin ma = vxij; mb = xij; end
      spfa_pkg::OP_VR2:  begin ma = vyij; mb = yij; end
      spfa_pkg::OP_R21:  begin ma = xij; mb = xij; end
      spfa_pkg::OP_R22:  begin ma = yij; mb = yij; end
      spfa_pkg::OP_T:    begin ma = $signed({1'b0, n_m}); mb = coef; end
      spfa_pkg::OP_AX:   begin ma = t; mb = n_gx; end
      spfa_pkg::OP_AY:   begin ma = t; mb = n_gy; end
      spfa_pkg::OP_AE:   begin ma = t; mb = vdw; end
      spfa_pkg::OP_V1:   begin ma = $signed({1'b0, hij}); mb = vr; end
      spfa_pkg::OP_V3:   begin ma = $signed({1'b0, alpha}); mb = $signed({1'b0, cij}); end
      spfa_pkg::OP_V4:   begin ma = p0; mb = phi; end
      spfa_pkg::OP_V5:   begin ma = phi; mb = phi; end
      spfa_pkg::OP_V6:   begin ma = $signed({1'b0, beta}); mb = p1; end
      spfa_pkg::OP_Q2:   begin ma = q; mb = q; end
      spfa_pkg::OP_Q4:   begin ma = q2; mb = q2; end
      spfa_pkg::OP_Q8:   begin ma = q4; mb = q4; end
      spfa_pkg::OP_Q12:  begin ma = q8; mb = q4; end
      spfa_pkg::OP_B7:   begin
        ma = $signed({1'b0, dstr});
        mb = spfa_pkg::sat32(64'(q12) - 64'(q4));
      end
      spfa_pkg::OP_BX:   begin ma = fac; mb = xij; end
      spfa_pkg::OP_BY:   begin ma = fac; mb = yij; end
      default:           begin ma = '0; mb = '0; end
    endcase
  end

  assign mprod  = 64'(ma) * 64'(mb);
  assign mshift = mprod >>> FRAC_BITS;
  assign mres   = spfa_pkg::sat32(mshift);

  always_comb begin
    case (cmd.dsel)
      spfa_pkg::DS_PI_C:  begin da = c_p; db = {1'b0, rhoi}; end
      spfa_pkg::DS_PI_C2: begin da = d0;  db = {1'b0, rhoi}; end
      spfa_pkg::DS_PI_N:  begin da = n_p; db = {1'b0, rhoj}; end
      spfa_pkg::DS_PI_N2: begin da = d0;  db = {1'b0, rhoj}; end
      spfa_pkg::DS_P0R2:  begin da = p0;  db = $unsigned(r2) + 32'd1; end
      spfa_pkg::DS_PIIJ:  begin da = num; db = {1'b0, rhoij} + 32'd1; end
      spfa_pkg::DS_Q:     begin da = $signed({1'b0, r0}); db = (r == '0) ? 32'd1 : r; end
      default:            begin da = '0;  db = 32'd1; end
    endcase
  end

  spfa_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk  (clk),
    .rst  (rst),
    .go   (cmd.div_go),
    .a    (da),
    .b    (db),
    .busy (div_busy),
    .q    (dq)
  );

  spfa_sqrt #(.FRAC_BITS(FRAC_BITS)) u_sqrt (
    .clk  (clk),
    .rst  (rst),
    .go   (cmd.sqrt_go),
    .r2   (r2[30:0]),
    .busy (sqrt_busy),
    .root (sroot)
  );

  assign emit_ok = !out_valid || out_ready;

  assign stat.action    = n_act;
  assign stat.vr_neg    = vr[31];
  assign stat.r_lt_r0   = (r < {1'b0, r0});
  assign stat.div_busy  = div_busy;
  assign stat.sqrt_busy = sqrt_busy;
  assign stat.emit_ok   = emit_ok;

  // control state: config, center, sums, output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      gravity   <= spfa_pkg::GRAVITY_RST;
      r0        <= spfa_pkg::BND_RADIUS_RST;
      dstr      <= spfa_pkg::BND_STRENG_RST;
      alpha     <= spfa_pkg::VISC_ALPHA_RST;
      beta      <= spfa_pkg::VISC_BETA_RST;
      c_px      <= '0;
      c_py      <= '0;
      c_vx      <= '0;
      c_vy      <= '0;
      c_rho     <= '0;
      c_p       <= '0;
      c_h       <= '0;
      c_c       <= '0;
      sum_x     <= '0;
      sum_y     <= '0;
      sum_e     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_wen) begin
        case (cfg_index)
          spfa_pkg::CFG_GRAVITY:    gravity <= $signed(cfg_data);
          spfa_pkg::CFG_BND_RADIUS: r0      <= cfg_data[30:0];
          spfa_pkg::CFG_BND_STRENG: dstr    <= cfg_data[30:0];
          spfa_pkg::CFG_VISC_ALPHA: alpha   <= cfg_data[30:0];
          spfa_pkg::CFG_VISC_BETA:  beta    <= cfg_data[30:0];
          default: ;
        endcase
      end
      case (cmd.op)
        spfa_pkg::OP_LOAD: begin
          c_px  <= n_px;
          c_py  <= n_py;
          c_vx  <= n_vx;
          c_vy  <= n_vy;
          c_rho <= n_rho;
          c_p   <= n_p;
          c_h   <= n_h;
          c_c   <= n_c;
          sum_x <= '0;
          sum_y <= '0;
          sum_e <= '0;
        end
        spfa_pkg::OP_AX: sum_x <= spfa_pkg::sat48(64'(sum_x) - 64'(mres));
        spfa_pkg::OP_AY: sum_y <= spfa_pkg::sat48(64'(sum_y) - 64'(mres));
        spfa_pkg::OP_AE: sum_e <= spfa_pkg::sat48(64'(sum_e) + 64'(mres >>> 1));
        spfa_pkg::OP_BX: sum_x <= spfa_pkg::sat48(64'(sum_x) + 64'(mres));
        spfa_pkg::OP_BY: sum_y <= spfa_pkg::sat48(64'(sum_y) + 64'(mres));
        default: ;
      endcase
      if (cmd.op == spfa_pkg::OP_EMIT && emit_ok) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload: captured word, intermediate terms, output word
  always_ff @(posedge clk) begin
    if (in_take) begin
      n_act <= in_action;
      n_px  <= $signed(in_data[spfa_pkg::POS_X_LSB +: 32]);
      n_py  <= $signed(in_data[spfa_pkg::POS_Y_LSB +: 32]);
      n_vx  <= $signed(in_data[spfa_pkg::VEL_X_LSB +: 32]);
      n_vy  <= $signed(in_data[spfa_pkg::VEL_Y_LSB +: 32]);
      n_rho <= in_data[spfa_pkg::DENSITY_LSB +: 31];
      n_p   <= $signed(in_data[spfa_pkg::PRESSURE_LSB +: 32]);
      n_h   <= in_data[spfa_pkg::SMOOTH_LSB +: 31];
      n_c   <= in_data[spfa_pkg::SOUND_LSB +: 31];
      n_m   <= in_data[spfa_pkg::MASS_LSB +: 31];
      n_gx  <= $signed(in_data[spfa_pkg::GRAD_X_LSB +: 32]);
      n_gy  <= $signed(in_data[spfa_pkg::GRAD_Y_LSB +: 32]);
    end
    case (cmd.op)
      spfa_pkg::OP_EMIT: begin
        if (emit_ok) begin
          out_data <= {spfa_pkg::sat32(64'(sum_e)),
                       spfa_pkg::sat32(64'(sum_y) + 64'(gravity)),
                       spfa_pkg::sat32(64'(sum_x))};
        end
      end
      spfa_pkg::OP_DIFF: begin
        xij   <= spfa_pkg::sat32(64'(c_px) - 64'(n_px));
        yij   <= spfa_pkg::sat32(64'(c_py) - 64'(n_py));
        vxij  <= spfa_pkg::sat32(64'(c_vx) - 64'(n_vx));
        vyij  <= spfa_pkg::sat32(64'(c_vy) - 64'(n_vy));
        rhoi  <= rhoi_c;
        rhoj  <= rhoj_c;
        hij   <= hsum[31:1];
        cij   <= csum[31:1];
        rhoij <= rsum[31:1];
      end
      spfa_pkg::OP_VDW1: p0  <= mres;
      spfa_pkg::OP_VDW2: vdw <= spfa_pkg::sat32(64'(p0) + 64'(mres));
      spfa_pkg::OP_VR1:  p0  <= mres;
      spfa_pkg::OP_VR2:  vr  <= spfa_pkg::sat32(64'(p0) + 64'(mres));
      spfa_pkg::OP_R21:  p0  <= mres;
      spfa_pkg::OP_R22:  r2  <= spfa_pkg::sat32(64'(p0) + 64'(mres));
      spfa_pkg::OP_WD0:  if (!div_busy) d0 <= dq;
      spfa_pkg::OP_WD1:  if (!div_busy) d1 <= dq;
      spfa_pkg::OP_WPIJ: if (!div_busy) coef <= spfa_pkg::sat32(64'(d1) + 64'(dq));
      spfa_pkg::OP_T:    t   <= mres;
      spfa_pkg::OP_V1:   p0  <= mres;
      spfa_pkg::OP_WPHI: if (!div_busy) phi <= dq;
      spfa_pkg::OP_V3:   p0  <= mres;
      spfa_pkg::OP_V4:   p0  <= mres;
      spfa_pkg::OP_V5:   p1  <= mres;
      spfa_pkg::OP_V6:   num <= spfa_pkg::sat32(64'(mres) - 64'(p0));
      spfa_pkg::OP_WCOEF: if (!div_busy) coef <= dq;
      spfa_pkg::OP_WR:   if (!sqrt_busy) r <= sroot;
      spfa_pkg::OP_WQ:   if (!div_busy) q <= dq;
      spfa_pkg::OP_Q2:   q2  <= mres;
      spfa_pkg::OP_Q4:   q4  <= mres;
      spfa_pkg::OP_Q8:   q8  <= mres;
      spfa_pkg::OP_Q12:  q12 <= mres;
      spfa_pkg::OP_B7:   p0  <= mres;
      spfa_pkg::OP_WFAC: if (!div_busy) fac <= dq;
      default: ;
    endcase
  end

endmodule

// ===== rtl/spfa_ctrl.sv =====
// controller: sequences one word through the datapath steps
module spfa_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  spfa_pkg::stat_t stat,
  output spfa_pkg::cmd_t  cmd
);

  typedef enum logic [5:0] {
    S_IDLE, S_DISP, S_LOAD, S_EMIT, S_DIFF,
    S_VDW1, S_VDW2, S_VR1, S_VR2, S_R21, S_R22,
    S_DPC, S_WPC, S_DPC2, S_WPC2, S_DPN, S_WPN, S_DPN2, S_WPN2,
    S_T1, S_T2, S_T3, S_T4,
    S_V1, S_DPHI, S_WPHI, S_V3, S_V4, S_V5, S_V6, S_DPII, S_WPII,
    S_SQGO, S_SQWT, S_CMP, S_DQ, S_WQ, S_Q2, S_Q4, S_Q8, S_Q12, S_B7,
    S_DFAC, S_WFAC, S_BX, S_BY
  } state_t;

  state_t state, state_next;
  logic   visc;

  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      visc  <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_IDLE) visc <= 1'b0;
      else if (state == S_V1) visc <= 1'b1;
    end
  end

  always_comb begin
    state_next  = state;
    cmd.op      = spfa_pkg::OP_NONE;
    cmd.div_go  = 1'b0;
    cmd.dsel    = spfa_pkg::DS_PI_C;
    cmd.sqrt_go = 1'b0;
    case (state)
      S_IDLE: if (in_valid) state_next = S_DISP;
      S_DISP: begin
        case (stat.action)
          spfa_pkg::ACT_LOAD: state_next = S_LOAD;
          spfa_pkg::ACT_EMIT: state_next = S_EMIT;
          default:            state_next = S_DIFF;
        endcase
      end
      S_LOAD: begin cmd.op = spfa_pkg::OP_LOAD; state_next = S_IDLE; end
      S_EMIT: begin
        cmd.op = spfa_pkg::OP_EMIT;
        if (stat.emit_ok) state_next = S_IDLE;
      end
      S_DIFF: begin cmd.op = spfa_pkg::OP_DIFF; state_next = S_VDW1; end
      S_VDW1: begin cmd.op = spfa_pkg::OP_VDW1; state_next = S_VDW2; end
      S_VDW2: begin cmd.op = spfa_pkg::OP_VDW2; state_next = S_VR1; end
      S_VR1:  begin cmd.op = spfa_pkg::OP_VR1; state_next = S_VR2; end
      S_VR2:  begin cmd.op = spfa_pkg::OP_VR2; state_next = S_R21; end
      S_R21:  begin cmd.op = spfa_pkg::OP_R21; state_next = S_R22; end
      S_R22:  begin cmd.op = spfa_pkg::OP_R22; state_next = S_DPC; end
      S_DPC:  begin cmd.div_go = 1'b1; cmd.dsel = spfa_pkg::DS_PI_C; state_next = S_WPC; end
      S_WPC:  begin cmd.op = spfa_pkg::OP_WD0; if (!stat.div_busy) state_next = S_DPC2; end
      S_DPC2: begin cmd.div_go = 1'b1; cmd.dsel = spfa_pkg::DS_PI_C2; state_next = S_WPC2; end
      S_WPC2: begin cmd.op = spfa_pkg::OP_WD1; if (!stat.div_busy) state_next = S_DPN; end
      S_DPN:  begin cmd.div_go = 1'b1; cmd.dsel = spfa_pkg::DS_PI_N; state_next = S_WPN; end
      S_WPN:  begin cmd.op = spfa_pkg::OP_WD0; if (!stat.div_busy) state_next = S_DPN2; end
      S_DPN2: begin cmd.div_go = 1'b1; cmd.dsel = spfa_pkg::DS_PI_N2; state_next = S_WPN2; end
      S_WPN2: begin cmd.op = spfa_pkg::OP_WPIJ; if (!stat.div_busy) state_next = S_T1; end
      S_T1:   begin cmd.op = spfa_pkg::OP_T; state_next = S_T2; end
      S_T2:   begin cmd.op = spfa_pkg::OP_AX; state_next = S_T3; end
      S_T3:   begin cmd.op = spfa_pkg::OP_AY; state_next = S_T4; end
      S_T4: begin
        cmd.op = spfa_pkg::OP_AE;
        if (!visc && stat.vr_neg) state_next = S_V1;
        else if (stat.action == spfa_pkg::ACT_BOUNDARY) state_next = S_SQGO;
        else state_next = S_IDLE;
      end
      S_V1:   begin cmd.op = spfa_pkg::OP_V1; state_next = S_DPHI; end
      S_DPHI: begin cmd.div_go = 1'b1; cmd.dsel = spfa_pkg::DS_P0R2; state_next = S_WPHI; end
      S_WPHI: begin cmd.op = spfa_pkg::OP_WPHI; if (!stat.div_busy) state_next = S_V3; end
      S_V3:   begin cmd.op = spfa_pkg::OP_V3; state_next = S_V4; end
      S_V4:   begin cmd.op = spfa_pkg::OP_V4; state_next = S_V5; end
      S_V5:   begin cmd.op = spfa_pkg::OP_V5; state_next = S_V6; end
      S_V6:   begin cmd.op = spfa_pkg::OP_V6; state_next = S_DPII; end
      S_DPII: begin cmd.div_go = 1'b1; cmd.dsel = spfa_pkg::DS_PIIJ; state_next = S_WPII; end
      S_WPII: begin cmd.op = spfa_pkg::OP_WCOEF; if (!stat.div_busy) state_next = S_T1; end
      S_SQGO: begin cmd.sqrt_go = 1'b1; state_next = S_SQWT; end
      S_SQWT: begin cmd.op = spfa_pkg::OP_WR; if (!stat.sqrt_busy) state_next = S_CMP; end
      S_CMP:  state_next = stat.r_lt_r0 ? S_DQ : S_IDLE;
      S_DQ:   begin cmd.div_go = 1'b1; cmd.dsel = spfa_pkg::DS_Q; state_next = S_WQ; end
      S_WQ:   begin cmd.op = spfa_pkg::OP_WQ; if (!stat.div_busy) state_next = S_Q2; end
      S_Q2:   begin cmd.op = spfa_pkg::OP_Q2; state_next = S_Q4; end
      S_Q4:   begin cmd.op = spfa_pkg::OP_Q4; state_next = S_Q8; end
      S_Q8:   begin cmd.op = spfa_pkg::OP_Q8; state_next = S_Q12; end
      S_Q12:  begin cmd.op = spfa_pkg::OP_Q12; state_next = S_B7; end
      S_B7:   begin cmd.op = spfa_pkg::OP_B7; state_next = S_DFAC; end
      S_DFAC: begin cmd.div_go = 1'b1; cmd.dsel = spfa_pkg::DS_P0R2; state_next = S_WFAC; end
      S_WFAC: begin cmd.op = spfa_pkg::OP_WFAC; if (!stat.div_busy) state_next = S_BX; end
      S_BX:   begin cmd.op = spfa_pkg::OP_BX; state_next = S_BY; end
      S_BY:   begin cmd.op = spfa_pkg::OP_BY; state_next = S_IDLE; end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// ===== rtl/sph_pair_force_accumulator.sv =====
// top level of the 2d sph pressure and viscosity force accumulator
//
// channel  dir  handshake          payload
// s        in   s_tvalid/s_tready  s_tdata (particle word), s_tuser (action)
// m        out  m_tvalid/m_tready  m_tdata (accel_x, accel_y, energy_rate)
// cfg      in   cfg_wen            cfg_index, cfg_data
//
// one word at a time; a load passes the dispatch and load states, an emit also
// waits for m_tready while an older result is still held; a neighbor runs four
// divisions on the one-bit-per-cycle divider, an approaching neighbor two more, and a
// boundary neighbor a square root plus, inside r0, another two divisions
// the output register holds a result while the next words are taken
// rst is synchronous and clears config to defaults, the center and the sums
module sph_pair_force_accumulator #(
  parameter int FRAC_BITS = spfa_pkg::FRAC_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // pos_x, pos_y, vel_x, vel_y, density, pressure, smoothing_len, sound_speed,
  // mass, grad_x, grad_y, zero pad
  input  logic [spfa_pkg::IN_TDATA_W-1:0]    s_tdata,
  // action
  input  logic [1:0]                         s_tuser,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // accel_x, accel_y, energy_rate
  output logic [spfa_pkg::OUT_TDATA_W-1:0]   m_tdata,
  input  logic                               cfg_wen,
  input  logic [spfa_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [31:0]                        cfg_data
);

  spfa_pkg::cmd_t  cmd;
  spfa_pkg::stat_t stat;
  logic            in_take;

  assign in_take = s_tvalid && s_tready;

  spfa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  spfa_datapath #(.FRAC_BITS(FRAC_BITS)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_take   (in_take),
    .in_action (s_tuser),
    .in_data   (s_tdata),
    .out_ready (m_tready),
    .out_valid (m_tvalid),
    .out_data  (m_tdata),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule

// ===== rtl/spfa_checker.sv =====
// port-level checker for the accumulator, bound to the top level
module spfa_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             s_tvalid,
  input logic                             s_tready,
  input logic                             m_tvalid,
  input logic                             m_tready,
  input logic [spfa_pkg::OUT_TDATA_W-1:0] m_tdata
);

  a_rst_clears_out: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled output word changed");

  a_one_word: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second word taken while busy");

  a_emit_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(!s_tready))
    else $error("result appeared while input side idle");

endmodule

bind sph_pair_force_accumulator spfa_checker u_spfa_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
